>>> rtl/pce_pkg.sv
// Shared types, register indexes, effect codes and fixed coefficients of the color effect unit.
package pce_pkg;

  localparam int PIX_W     = 8;
  localparam int MODE_W    = 3;
  localparam int ROW_BITS  = 54;
  localparam int SLOT_BITS = 18;
  localparam int CFG_IDX_W = 2;
  localparam int FIX_W     = 12;

  typedef logic [PIX_W-1:0]     pix_t;
  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [ROW_BITS-1:0]  row_t;
  typedef logic [FIX_W-1:0]     fix_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t REG_MODE = 2'd0;
  localparam cfg_idx_t REG_ROW0 = 2'd1;
  localparam cfg_idx_t REG_ROW1 = 2'd2;
  localparam cfg_idx_t REG_ROW2 = 2'd3;

  // Effect codes.
  localparam mode_t MODE_PASS   = 3'd0;
  localparam mode_t MODE_MATRIX = 3'd1;
  localparam mode_t MODE_WARM   = 3'd2;
  localparam mode_t MODE_COOL   = 3'd3;
  localparam mode_t MODE_SEPIA  = 3'd4;
  localparam mode_t MODE_GREEN  = 3'd5;
  localparam mode_t MODE_MIX    = 3'd6;

  // Datapath kinds carried down the pipeline.
  localparam logic [1:0] KIND_PASS = 2'd0;
  localparam logic [1:0] KIND_MAC  = 2'd1;
  localparam logic [1:0] KIND_MIX  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       frac10;
  } pce_sel_t;

  // Per-channel gains, scaled by 1024, in B, G, R order.
  localparam fix_t WARM_B  = 12'd922;
  localparam fix_t WARM_G  = 12'd1075;
  localparam fix_t WARM_R  = 12'd1229;
  localparam fix_t COOL_B  = 12'd1229;
  localparam fix_t COOL_G  = 12'd973;
  localparam fix_t COOL_R  = 12'd870;
  localparam fix_t GREEN_B = 12'd819;
  localparam fix_t GREEN_G = 12'd1536;
  localparam fix_t GREEN_R = 12'd614;

  // Sepia matrix scaled by 1024; entry row*3+col, rows B,G,R out, columns B,G,R in.
  localparam fix_t SEPIA [9] = '{
    12'd134, 12'd547, 12'd279,
    12'd172, 12'd702, 12'd357,
    12'd194, 12'd787, 12'd402
  };

  // Reciprocal of three for values below 2048: x / 3 == (x * 683) >> 11.
  localparam int RECIP3       = 683;
  localparam int RECIP3_SHIFT = 11;

endpackage

>>> rtl/pce_cfg_regs.sv
// Configuration registers and per-mode coefficient selection of the color effect unit.
module pce_cfg_regs import pce_pkg::*; #(
  parameter int COEF_WIDTH = 18
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  cfg_idx_t                 cfg_index,
  input  row_t                     cfg_data,
  output logic [8:0][COEF_WIDTH-1:0] coef,
  output pce_sel_t                 sel
);

  localparam logic [COEF_WIDTH-1:0] ONE_Q8 = COEF_WIDTH'(256);

  mode_t                          mode_r;
  logic [2:0][2:0][COEF_WIDTH-1:0] row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PASS;
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          row_r[i][c] <= (i == c) ? ONE_Q8 : '0;
        end
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: mode_r <= cfg_data[MODE_W-1:0];
        REG_ROW0: for (int c = 0; c < 3; c++) row_r[0][c] <= cfg_data[SLOT_BITS*c +: COEF_WIDTH];
        REG_ROW1: for (int c = 0; c < 3; c++) row_r[1][c] <= cfg_data[SLOT_BITS*c +: COEF_WIDTH];
        REG_ROW2: for (int c = 0; c < 3; c++) row_r[2][c] <= cfg_data[SLOT_BITS*c +: COEF_WIDTH];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef       = '0;
    sel.kind   = KIND_MAC;
    sel.frac10 = 1'b1;
    case (mode_r)
      MODE_MATRIX: begin
        sel.frac10 = 1'b0;
        for (int i = 0; i < 3; i++) begin
          for (int c = 0; c < 3; c++) begin
            coef[i*3+c] = row_r[i][c];
          end
        end
      end
      MODE_WARM: begin
        coef[0] = COEF_WIDTH'(WARM_B);
        coef[4] = COEF_WIDTH'(WARM_G);
        coef[8] = COEF_WIDTH'(WARM_R);
      end
      MODE_COOL: begin
        coef[0] = COEF_WIDTH'(COOL_B);
        coef[4] = COEF_WIDTH'(COOL_G);
        coef[8] = COEF_WIDTH'(COOL_R);
      end
      MODE_GREEN: begin
        coef[0] = COEF_WIDTH'(GREEN_B);
        coef[4] = COEF_WIDTH'(GREEN_G);
        coef[8] = COEF_WIDTH'(GREEN_R);
      end
      MODE_SEPIA: begin
        for (int k = 0; k < 9; k++) begin
          coef[k] = COEF_WIDTH'(SEPIA[k]);
        end
      end
      MODE_MIX: sel.kind = KIND_MIX;
      default:  sel.kind = KIND_PASS;
    endcase
  end

endmodule

>>> rtl/pce_mac_row.sv
// One output channel: three products, their sum with rounding, and the clamp to 0..255.
module pce_mac_row import pce_pkg::*; #(
  parameter int COEF_WIDTH = 18
) (
  input  logic                  clk,
  input  logic [2:0][COEF_WIDTH-1:0] coef,
  input  logic                  frac10,
  input  pix_t                  b,
  input  pix_t                  g,
  input  pix_t                  r,
  output pix_t                  res
);

  localparam int PW = COEF_WIDTH + PIX_W + 1;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] prod_r [3];
  logic                 frac10_s2_r;
  logic                 frac10_s3_r;
  logic signed [SW-1:0] sum_r;
  logic signed [SW-1:0] sum_nxt;
  logic signed [SW-1:0] shifted;
  pix_t                 pix [3];

  assign pix[0] = b;
  assign pix[1] = g;
  assign pix[2] = r;

  // Stage two: one signed multiply per input channel, both operands at full product width.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= $signed({{(PW-COEF_WIDTH){coef[c][COEF_WIDTH-1]}}, coef[c]}) *
                   $signed({{(PW-PIX_W){1'b0}}, pix[c]});
    end
    frac10_s2_r <= frac10;
  end

  // Stage three: sum plus half an output step.
  always_comb begin
    sum_nxt = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]);
    sum_nxt = sum_nxt + (frac10_s2_r ? SW'(512) : SW'(128));
  end

  always_ff @(posedge clk) begin
    sum_r       <= sum_nxt;
    frac10_s3_r <= frac10_s2_r;
  end

  // Clamp: a negative sum gives zero, anything above eight bits gives full scale.
  assign shifted = frac10_s3_r ? (sum_r >>> 10) : (sum_r >>> 8);

  always_comb begin
    if (sum_r[SW-1]) begin
      res = '0;
    end else if (shifted[SW-1:PIX_W] != '0) begin
      res = '1;
    end else begin
      res = shifted[PIX_W-1:0];
    end
  end

endmodule

>>> rtl/pixel_color_effect_unit.sv
// Top level of the pixel color effect unit: input stage, mix path, matrix rows and output stage.
//
//   channel   handshake            payload
//   input     start / busy         in_blue_in, in_green_in, in_red_in
//   result    out_valid (strobe)   out_blue_out, out_green_out, out_red_out
//   config    cfg_we               cfg_index, cfg_data
//
// One pixel can be taken every cycle; busy stays low because the pipeline never stalls.
// Each result passes through four register stages: input register, multiply, sum and round,
// clamp and select.
// The multiplier stage sets the clock.
// Reset clears the stage valids, selects pass-through and loads the identity matrix.
// The receiver cannot stall, so results leave on a fixed schedule.
module pixel_color_effect_unit import pce_pkg::*; #(
  parameter int COEF_WIDTH = 18
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pix_t     in_blue_in,
  input  pix_t     in_green_in,
  input  pix_t     in_red_in,
  output logic     out_valid,
  output pix_t     out_blue_out,
  output pix_t     out_green_out,
  output pix_t     out_red_out,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  row_t     cfg_data
);

  localparam int SUM3_W = PIX_W + 2;
  localparam int QPROD_W = SUM3_W + RECIP3_SHIFT;

  logic [8:0][COEF_WIDTH-1:0] coef;
  logic [8:0][COEF_WIDTH-1:0] coef_r;
  pce_sel_t                   sel;
  pce_sel_t                   sel_s1_r;
  logic [1:0]                 kind_s2_r;
  logic [1:0]                 kind_s3_r;
  logic                       v_s1_r;
  logic                       v_s2_r;
  logic                       v_s3_r;
  logic                       out_valid_r;
  logic                       in_xfer;
  pix_t                       b_s1_r;
  pix_t                       g_s1_r;
  pix_t                       r_s1_r;
  pix_t                       b_s2_r;
  pix_t                       g_s2_r;
  pix_t                       r_s2_r;
  pix_t                       b_s3_r;
  pix_t                       g_s3_r;
  pix_t                       r_s3_r;
  pix_t                       inv_s2_r;
  logic [SUM3_W-1:0]          sum3_s2_r;
  pix_t                       diff_s2_r;
  pix_t                       inv_s3_r;
  pix_t                       avg_s3_r;
  pix_t                       mred_s3_r;
  logic [QPROD_W-1:0]         qprod;
  logic [SUM3_W-1:0]          tri3;
  pix_t                       row_res [3];
  pix_t                       ob_nxt;
  pix_t                       og_nxt;
  pix_t                       or_nxt;
  pix_t                       ob_r;
  pix_t                       og_r;
  pix_t                       or_r;

  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  pce_cfg_regs #(.COEF_WIDTH(COEF_WIDTH)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef),
    .sel       (sel)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r      <= 1'b0;
      v_s2_r      <= 1'b0;
      v_s3_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_s1_r      <= in_xfer;
      v_s2_r      <= v_s1_r;
      v_s3_r      <= v_s2_r;
      out_valid_r <= v_s3_r;
    end
  end

  // Stage one: capture the pixel with the coefficients of the current mode.
  always_ff @(posedge clk) begin
    b_s1_r   <= in_blue_in;
    g_s1_r   <= in_green_in;
    r_s1_r   <= in_red_in;
    coef_r   <= coef;
    sel_s1_r <= sel;
  end

  generate
    for (genvar i = 0; i < 3; i++) begin : g_row
      pce_mac_row #(.COEF_WIDTH(COEF_WIDTH)) u_row (
        .clk    (clk),
        .coef   (coef_r[i*3 +: 3]),
        .frac10 (sel_s1_r.frac10),
        .b      (b_s1_r),
        .g      (g_s1_r),
        .r      (r_s1_r),
        .res    (row_res[i])
      );
    end
  endgenerate

  // Stage two: mix path operands, and the raw pixel for pass-through.
  always_ff @(posedge clk) begin
    kind_s2_r <= sel_s1_r.kind;
    b_s2_r    <= b_s1_r;
    g_s2_r    <= g_s1_r;
    r_s2_r    <= r_s1_r;
    inv_s2_r  <= 8'd255 - r_s1_r;
    sum3_s2_r <= SUM3_W'(b_s1_r) + SUM3_W'(g_s1_r) + SUM3_W'(r_s1_r) + SUM3_W'(1);
    diff_s2_r <= (b_s1_r > g_s1_r) ? (b_s1_r - g_s1_r) : (g_s1_r - b_s1_r);
  end

  // Stage three: average by reciprocal multiply, and 1.5 times the difference.
  assign qprod = QPROD_W'(sum3_s2_r) * QPROD_W'(RECIP3);
  assign tri3  = SUM3_W'(diff_s2_r) + SUM3_W'({diff_s2_r, 1'b0}) + SUM3_W'(1);

  always_ff @(posedge clk) begin
    kind_s3_r <= kind_s2_r;
    b_s3_r    <= b_s2_r;
    g_s3_r    <= g_s2_r;
    r_s3_r    <= r_s2_r;
    inv_s3_r  <= inv_s2_r;
    avg_s3_r  <= qprod[RECIP3_SHIFT +: PIX_W];
    mred_s3_r <= tri3[SUM3_W-1] ? 8'd255 : tri3[PIX_W:1];
  end

  // Stage four: pick the result of the item's effect.
  always_comb begin
    case (kind_s3_r)
      KIND_MAC: begin
        ob_nxt = row_res[0];
        og_nxt = row_res[1];
        or_nxt = row_res[2];
      end
      KIND_MIX: begin
        ob_nxt = inv_s3_r;
        og_nxt = avg_s3_r;
        or_nxt = mred_s3_r;
      end
      default: begin
        ob_nxt = b_s3_r;
        og_nxt = g_s3_r;
        or_nxt = r_s3_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    og_r <= og_nxt;
    or_r <= or_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_blue_out  = ob_r;
  assign out_green_out = og_r;
  assign out_red_out   = or_r;

  // Every result strobe goes back to an earlier transfer.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(in_xfer, 4))
    else $error("result strobe without a matching transfer");

  // Pass-through results carry the blue and red inputs unchanged.
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && $past(kind_s3_r) == KIND_PASS) |->
      (out_blue_out == $past(in_blue_in, 4) && out_red_out == $past(in_red_in, 4)))
    else $error("pass-through result differs from input");

  // In the mix effect, blue is the inverted red input.
  a_mix_blue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && $past(kind_s3_r) == KIND_MIX) |->
      (out_blue_out == 8'd255 - $past(in_red_in, 4)))
    else $error("mix blue is not inverted red");

endmodule
